### design/lrc_pkg.sv
// Shared types, codes and sizes of the buffer cache tag manager.
package lrc_pkg;

	localparam int NUM_BUFFERS = 32;
	localparam int IDX_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [IDX_W-1:0] rank_t;
	typedef logic [7:0]       cnt_t;
	typedef logic [1:0]       op_t;
	typedef logic [1:0]       status_t;
	typedef logic [4:0]       slot_t;

	localparam op_t OP_GET     = 2'd0;
	localparam op_t OP_RELEASE = 2'd1;
	localparam op_t OP_PIN     = 2'd2;
	localparam op_t OP_UNPIN   = 2'd3;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_NOFREE = 2'd1;
	localparam status_t ST_UNDER  = 2'd2;
	localparam status_t ST_OVER   = 2'd3;

	localparam cnt_t CNT_MAX = 8'd255;

	// Running result of the search that moves along the cell row.
	typedef struct packed {
		logic  hit_found;
		idx_t  hit_slot;
		rank_t hit_rank;
		logic  free_found;
		idx_t  free_slot;
		rank_t free_rank;
	} best_t;

	// Update command broadcast to every cell.
	typedef struct packed {
		logic        wr;
		idx_t        slot;
		cnt_t        new_cnt;
		logic        set_tags;
		logic        set_valid;
		logic        touch;
		rank_t       touch_rank;
		logic [7:0]  device;
		logic [31:0] block_number;
	} cmd_t;

endpackage

### design/lrc_req_if.sv
// Request channel: valid/ready handshake with the get/release/pin/unpin payload.
interface lrc_req_if;
	import lrc_pkg::*;

	logic        valid;
	logic        ready;
	op_t         op;
	logic [7:0]  device;
	logic [31:0] block_number;
	slot_t       slot;

	modport source (output valid, op, device, block_number, slot, input ready);
	modport sink   (input valid, op, device, block_number, slot, output ready);
endinterface

### design/lrc_rsp_if.sv
// Response channel: valid/ready handshake with the result payload.
interface lrc_rsp_if;
	import lrc_pkg::*;

	logic    valid;
	logic    ready;
	slot_t   result_slot;
	logic    hit;
	logic    needs_read;
	status_t status;
	cnt_t    count_after;

	modport source (output valid, result_slot, hit, needs_read, status, count_after,
		input ready);
	modport sink   (input valid, result_slot, hit, needs_read, status, count_after,
		output ready);
endinterface

### design/lrc_cell.sv
// One cache slot: tags, valid mark, count, recency rank and one search step.
module lrc_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  lrc_pkg::idx_t my_idx,
	input  lrc_pkg::cmd_t cmd,
	input  lrc_pkg::best_t best_in,
	output lrc_pkg::best_t best_out,
	output lrc_pkg::cnt_t cnt,
	output logic          vld,
	output lrc_pkg::rank_t rank
);
	import lrc_pkg::*;

	logic [7:0]  dev_q;
	logic [31:0] blk_q;
	logic        vld_q;
	cnt_t        cnt_q;
	rank_t       rank_q;
	best_t       best_q;
	best_t       best_d;
	logic        sel;

	assign sel = cmd.wr && (cmd.slot == my_idx);

	// Merge this slot into the running search
	always_comb begin
		best_d = best_in;
		if (dev_q == cmd.device && blk_q == cmd.block_number &&
			(!best_in.hit_found || rank_q < best_in.hit_rank)) begin
			best_d.hit_found = 1'b1;
			best_d.hit_slot  = my_idx;
			best_d.hit_rank  = rank_q;
		end
		if (cnt_q == '0 && (!best_in.free_found || rank_q > best_in.free_rank)) begin
			best_d.free_found = 1'b1;
			best_d.free_slot  = my_idx;
			best_d.free_rank  = rank_q;
		end
	end

	// Hand the search to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else begin
			best_q <= best_d;
		end
	end

	// Apply the broadcast update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q  <= '0;
			blk_q  <= '0;
			vld_q  <= 1'b0;
			cnt_q  <= '0;
			rank_q <= rank_t'(NUM_BUFFERS - 1) - my_idx;
		end else begin
			if (sel) begin
				cnt_q <= cmd.new_cnt;
				if (cmd.set_tags) begin
					dev_q <= cmd.device;
					blk_q <= cmd.block_number;
				end
				if (cmd.set_valid) begin
					vld_q <= 1'b1;
				end
			end
			if (cmd.touch) begin
				if (cmd.slot == my_idx) begin
					rank_q <= '0;
				end else if (rank_q < cmd.touch_rank) begin
					rank_q <= rank_q + 1'b1;
				end
			end
		end
	end

	assign best_out = best_q;
	assign cnt      = cnt_q;
	assign vld      = vld_q;
	assign rank     = rank_q;
endmodule

### design/lru_refcounted_block_cache_tags.sv
// Top level of the reference-counted LRU buffer cache tag manager.
// Tag and replacement manager for a buffer cache of NUM_BUFFERS slots, built as a row
// of slot cells. A get walks a search token down the row, one cell per cycle, to find
// the most recent matching tag and the least recent free slot. Its result is stored once
// the token has crossed the row, and the next request can be accepted in the cycle after
// the store. Release, pin and unpin need no search: they go from acceptance straight to
// the apply step. One request is worked on at a time. The result waits in an output
// register, and the next request is accepted while it waits. A request whose result
// finds that register still full holds in its last step until the receiver takes the
// waiting result.
module lru_refcounted_block_cache_tags (
	input logic     clk,
	input logic     arst_n,
	lrc_req_if.sink   req,
	lrc_rsp_if.source rsp
);
	import lrc_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;

	logic [1:0]  state_q;
	idx_t        scan_q;
	op_t         op_q;
	logic [7:0]  dev_q;
	logic [31:0] blk_q;
	slot_t       slot_q;

	best_t best_w [NUM_BUFFERS+1];
	cnt_t  cnt_w  [NUM_BUFFERS];
	logic  vld_w  [NUM_BUFFERS];
	rank_t rank_w [NUM_BUFFERS];

	cmd_t    cmd_d;
	cmd_t    cmd;
	idx_t    tgt;
	slot_t   o_slot;
	logic    o_hit;
	logic    o_nr;
	status_t o_st;
	cnt_t    o_cnt;
	logic    go;

	logic    rsp_valid_q;
	slot_t   rsp_slot_q;
	logic    rsp_hit_q;
	logic    rsp_nr_q;
	status_t rsp_st_q;
	cnt_t    rsp_cnt_q;

	assign best_w[0] = '0;

	// Row of slot cells
	for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
		lrc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.my_idx   (idx_t'(g)),
			.cmd      (cmd),
			.best_in  (best_w[g]),
			.best_out (best_w[g+1]),
			.cnt      (cnt_w[g]),
			.vld      (vld_w[g]),
			.rank     (rank_w[g])
		);
	end

	assign req.ready = (state_q == S_IDLE);
	assign go        = (state_q == S_APPLY) && (!rsp_valid_q || rsp.ready);

	// Decide the update and the result of the held request
	always_comb begin
		cmd_d              = '0;
		cmd_d.device       = dev_q;
		cmd_d.block_number = blk_q;
		tgt                = idx_t'(slot_q);
		o_slot             = slot_q;
		o_hit              = 1'b0;
		o_nr               = 1'b0;
		o_st               = ST_OK;
		o_cnt              = '0;
		if (op_q == OP_GET) begin
			if (best_w[NUM_BUFFERS].hit_found) begin
				tgt             = best_w[NUM_BUFFERS].hit_slot;
				o_slot          = slot_t'(tgt);
				o_hit           = 1'b1;
				o_nr            = !vld_w[tgt];
				cmd_d.wr        = 1'b1;
				cmd_d.set_valid = 1'b1;
				if (cnt_w[tgt] == CNT_MAX) begin
					o_st  = ST_OVER;
					o_cnt = CNT_MAX;
				end else begin
					o_cnt = cnt_w[tgt] + 1'b1;
				end
				cmd_d.new_cnt = o_cnt;
			end else if (best_w[NUM_BUFFERS].free_found) begin
				tgt             = best_w[NUM_BUFFERS].free_slot;
				o_slot          = slot_t'(tgt);
				o_nr            = 1'b1;
				o_cnt           = 8'd1;
				cmd_d.wr        = 1'b1;
				cmd_d.set_tags  = 1'b1;
				cmd_d.set_valid = 1'b1;
				cmd_d.new_cnt   = o_cnt;
			end else begin
				o_slot = '0;
				o_st   = ST_NOFREE;
			end
		end else if (32'(slot_q) >= NUM_BUFFERS) begin
			o_st = ST_NOFREE;
		end else if (op_q == OP_PIN) begin
			cmd_d.wr = 1'b1;
			if (cnt_w[tgt] == CNT_MAX) begin
				o_st  = ST_OVER;
				o_cnt = CNT_MAX;
			end else begin
				o_cnt = cnt_w[tgt] + 1'b1;
			end
			cmd_d.new_cnt = o_cnt;
		end else if (cnt_w[tgt] == '0) begin
			o_st = ST_UNDER;
		end else begin
			o_cnt            = cnt_w[tgt] - 1'b1;
			cmd_d.wr         = 1'b1;
			cmd_d.new_cnt    = o_cnt;
			cmd_d.touch      = (op_q == OP_RELEASE) && (o_cnt == '0);
			cmd_d.touch_rank = rank_w[tgt];
		end
		cmd_d.slot = tgt;
	end

	// Drop the update unless the result can be stored this cycle
	always_comb begin
		cmd       = cmd_d;
		cmd.wr    = cmd_d.wr && go;
		cmd.touch = cmd_d.touch && go;
	end

	// Sequence: accept, scan the row for a get, apply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					scan_q <= '0;
					if (req.valid) begin
						state_q <= (req.op == OP_GET) ? S_SCAN : S_APPLY;
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == idx_t'(NUM_BUFFERS - 1)) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the accepted transaction
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q   <= req.op;
			dev_q  <= req.device;
			blk_q  <= req.block_number;
			slot_q <= req.slot;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_slot_q <= o_slot;
			rsp_hit_q  <= o_hit;
			rsp_nr_q   <= o_nr;
			rsp_st_q   <= o_st;
			rsp_cnt_q  <= o_cnt;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_slot = rsp_slot_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.needs_read  = rsp_nr_q;
	assign rsp.status      = rsp_st_q;
	assign rsp.count_after = rsp_cnt_q;

	// A request is worked on alone until its result is stored
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in flight");

	// A hit is never reported as a failed allocation
	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> (rsp.status == ST_OK || rsp.status == ST_OVER))
		else $error("hit with bad status");

	// Underflow and no-free leave a zero count
	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_UNDER || rsp.status == ST_NOFREE)
		|-> rsp.count_after == '0)
		else $error("error result with nonzero count");

	// A get in the search step moves on only to further search or to the apply step
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |=> state_q == S_SCAN || state_q == S_APPLY)
		else $error("search left early");
endmodule
